FILE: design/jpeg_exif_orientation_parser_assert.svh
// Assertion macros used by the orientation parser RTL.
`ifndef JPEG_EXIF_ORIENTATION_PARSER_ASSERT_SVH
`define JPEG_EXIF_ORIENTATION_PARSER_ASSERT_SVH
`ifndef ASSERT_OFF
// Property checked on every rising clock edge outside reset.
`define JEOP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("jeop assertion failed");
// Condition that must never be true.
`define JEOP_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `JEOP_ASSERT(lbl, clk, rst_n, !(cond))
`else
`define JEOP_ASSERT(lbl, clk, rst_n, prop)
`define JEOP_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

FILE: design/jeop_pkg.sv
// Types, constants and helpers of the EXIF orientation parser.
`default_nettype none
package jeop_pkg;

  // Parser phases
  typedef enum logic [3:0] {
    PH_SOI0, PH_SOI1, PH_MARK, PH_CODE, PH_LEN_HI, PH_LEN_LO,
    PH_SKIP, PH_SIG, PH_TIFF, PH_IFD, PH_HOLD, PH_DONE
  } phase_e;

  localparam logic [7:0]  MARK_PREFIX   = 8'hFF;
  localparam logic [7:0]  CODE_SOI      = 8'hD8;
  localparam logic [7:0]  CODE_EOI      = 8'hD9;
  localparam logic [7:0]  CODE_SOS      = 8'hDA;
  localparam logic [7:0]  CODE_RST0     = 8'hD0;
  localparam logic [7:0]  CODE_RST7     = 8'hD7;
  localparam logic [7:0]  CODE_APP1     = 8'hE1;
  localparam logic [7:0]  BO_MOTOROLA   = 8'h4D;
  localparam logic [7:0]  BO_INTEL      = 8'h49;
  localparam logic [15:0] TIFF_MAGIC    = 16'h002A;
  localparam logic [15:0] TAG_ORIENT    = 16'h0112;
  localparam logic [15:0] TYPE_SHORT    = 16'h0003;
  localparam logic [3:0]  ENTRY_LAST    = 4'd11;
  localparam logic [3:0]  ORIENT_NORMAL = 4'd1;
  localparam logic [3:0]  ORIENT_MAX    = 4'd8;

  // Input queue between front and back
  localparam int unsigned IQ_DEPTH = 4;
  localparam int unsigned IQ_AW    = $clog2(IQ_DEPTH);
  // Result queue
  localparam int unsigned RQ_DEPTH = 2;
  localparam int unsigned RQ_AW    = $clog2(RQ_DEPTH);

  // Byte classes found by the front
  typedef struct packed {
    logic is_ff;
    logic is_soi;
    logic is_sos;
    logic is_standalone;
  } byte_class_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        eof;
    byte_class_t cls;
  } item_t;

  // Bytes of the "Exif\0\0" signature
  function automatic logic [7:0] exif_sig_byte(input logic [2:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0:    r = 8'h45;
      3'd1:    r = 8'h78;
      3'd2:    r = 8'h69;
      3'd3:    r = 8'h66;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // 16-bit value from two bytes in file order
  function automatic logic [15:0] get16(input logic be, input logic [7:0] b0,
                                        input logic [7:0] b1);
    return be ? {b0, b1} : {b1, b0};
  endfunction

endpackage
`default_nettype wire

FILE: design/jeop_front.sv
// Front part: classifies incoming bytes and queues them for the parser.
`default_nettype none
module jeop_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  output logic               full_o,
  input  wire logic [7:0]    stream_byte_i,
  input  wire logic          end_of_file_i,
  output jeop_pkg::item_t    item_o,
  output logic               item_valid_o,
  input  wire logic          item_pop_i
);

  jeop_pkg::item_t             mem_q [jeop_pkg::IQ_DEPTH];
  jeop_pkg::item_t             in_item;
  logic [jeop_pkg::IQ_AW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [jeop_pkg::IQ_AW:0]    cnt_q, cnt_d;
  logic                        wr, rd;

  // Byte classification
  always_comb begin
    in_item.data              = stream_byte_i;
    in_item.eof               = end_of_file_i;
    in_item.cls.is_ff         = (stream_byte_i == jeop_pkg::MARK_PREFIX);
    in_item.cls.is_soi        = (stream_byte_i == jeop_pkg::CODE_SOI);
    in_item.cls.is_sos        = (stream_byte_i == jeop_pkg::CODE_SOS);
    in_item.cls.is_standalone = (stream_byte_i == jeop_pkg::CODE_SOI) ||
                                (stream_byte_i == jeop_pkg::CODE_EOI) ||
                                ((stream_byte_i >= jeop_pkg::CODE_RST0) &&
                                 (stream_byte_i <= jeop_pkg::CODE_RST7));
  end

  assign full_o       = (cnt_q == (jeop_pkg::IQ_AW+1)'(jeop_pkg::IQ_DEPTH));
  assign item_valid_o = (cnt_q != '0);
  assign wr           = push_i && !full_o;
  assign rd           = item_pop_i && item_valid_o;
  assign item_o       = mem_q[rd_ptr_q];

  // Pointer and fill count
  always_comb begin
    wr_ptr_d = wr ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = rd ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + (jeop_pkg::IQ_AW+1)'(wr) - (jeop_pkg::IQ_AW+1)'(rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_ptr_q] <= in_item;
    end
  end

endmodule
`default_nettype wire

FILE: design/jeop_rq.sv
// Result queue: holds orientation codes until the consumer pops them.
`default_nettype none
module jeop_rq (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       wr_i,
  input  wire logic [3:0] data_i,
  output logic            full_o,
  output logic            empty_o,
  input  wire logic       pop_i,
  output logic [3:0]      data_o
);

  logic [3:0]                  mem_q [jeop_pkg::RQ_DEPTH];
  logic [jeop_pkg::RQ_AW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [jeop_pkg::RQ_AW:0]    cnt_q;
  logic                        wr, rd;

  assign full_o  = (cnt_q == (jeop_pkg::RQ_AW+1)'(jeop_pkg::RQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign wr      = wr_i && !full_o;
  assign rd      = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (rd) rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_q + (jeop_pkg::RQ_AW+1)'(wr) - (jeop_pkg::RQ_AW+1)'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

FILE: design/jeop_back.sv
// Back part: marker/segment parser, TIFF header check and IFD0 tag scan.
`default_nettype none
`include "jpeg_exif_orientation_parser_assert.svh"
module jeop_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire jeop_pkg::item_t item_i,
  input  wire logic            valid_i,
  output logic                 pop_o,
  input  wire logic            res_full_i,
  output logic                 res_wr_o,
  output logic [3:0]           res_data_o
);

  jeop_pkg::phase_e phase_q, phase_d;
  logic [15:0] seg_pos_q, seg_pos_d, seg_len_q, seg_len_d;
  logic [7:0]  marker_q, marker_d;
  logic        be_q, be_d;
  logic [7:0]  hdr_q [8];
  logic [7:0]  hdr_d [8];
  logic [15:0] ifd_off_q, ifd_off_d;
  logic [15:0] ent_cnt_q, ent_cnt_d, ent_idx_q, ent_idx_d;
  logic [7:0]  ent_b_q [4];
  logic [7:0]  ent_b_d [4];
  logic [7:0]  ent8_q, ent8_d;
  logic [3:0]  ent_pos_q, ent_pos_d;
  logic [3:0]  pend_q, pend_d;
  logic        given_q, given_d;
  logic        replay_q, replay_d;
  logic [2:0]  rp_q, rp_d;

  // Scratch values of the combinational step
  logic        go, give, tail, enter_replay;
  logic [3:0]  answer;
  logic [7:0]  b, ib;
  logic [15:0] tp, len_now, cnt16, tag16, typ16, val16, off16, pos_inc;
  logic [16:0] idx_inc;
  logic [20:0] need, tiff_sz;
  logic [31:0] off32;
  logic        be_new, bo_ok, ifd_en;

  assign b  = item_i.data;
  assign go = valid_i && !res_full_i;

  // Next state and outputs
  always_comb begin
    phase_d   = phase_q;
    seg_pos_d = seg_pos_q;
    seg_len_d = seg_len_q;
    marker_d  = marker_q;
    be_d      = be_q;
    hdr_d     = hdr_q;
    ifd_off_d = ifd_off_q;
    ent_cnt_d = ent_cnt_q;
    ent_idx_d = ent_idx_q;
    ent_b_d   = ent_b_q;
    ent8_d    = ent8_q;
    ent_pos_d = ent_pos_q;
    pend_d    = pend_q;
    given_d   = given_q;
    replay_d  = replay_q;
    rp_d      = rp_q;
    give      = 1'b0;
    tail      = 1'b0;
    enter_replay = 1'b0;
    answer    = jeop_pkg::ORIENT_NORMAL;
    res_wr_o  = 1'b0;
    res_data_o = jeop_pkg::ORIENT_NORMAL;
    pop_o     = 1'b0;
    len_now   = {seg_len_q[15:8], b};
    pos_inc   = seg_pos_q + 16'd1;
    tiff_sz   = {5'd0, seg_len_q - 16'd8};
    be_new    = be_q;
    bo_ok     = 1'b0;
    off32     = '0;
    off16     = '0;
    cnt16     = '0;
    tag16     = '0;
    typ16     = '0;
    val16     = '0;
    need      = '0;
    idx_inc   = '0;

    // IFD byte source: header copy during replay, else the stream
    if (replay_q) begin
      tp = {13'd0, rp_q};
      ib = hdr_q[rp_q];
    end else begin
      tp = seg_pos_q - 16'd6;
      ib = b;
    end
    ifd_en = 1'b0;

    if (go) begin
      if (replay_q) begin
        ifd_en = (phase_q == jeop_pkg::PH_IFD);
        rp_d   = rp_q + 3'd1;
        if (rp_q == 3'd7) begin
          replay_d = 1'b0;
          tail     = 1'b1;
        end
      end else begin
        unique case (phase_q)
          jeop_pkg::PH_SOI0: begin
            if (item_i.cls.is_ff) phase_d = jeop_pkg::PH_SOI1;
            else give = 1'b1;
          end
          jeop_pkg::PH_SOI1: begin
            if (item_i.cls.is_soi) phase_d = jeop_pkg::PH_MARK;
            else give = 1'b1;
          end
          jeop_pkg::PH_MARK: begin
            if (item_i.cls.is_ff) phase_d = jeop_pkg::PH_CODE;
            else give = 1'b1;
          end
          jeop_pkg::PH_CODE: begin
            priority if (item_i.cls.is_ff) begin
              phase_d = jeop_pkg::PH_CODE;
            end else if (item_i.cls.is_sos) begin
              give = 1'b1;
            end else if (item_i.cls.is_standalone) begin
              phase_d = jeop_pkg::PH_MARK;
            end else begin
              marker_d = b;
              phase_d  = jeop_pkg::PH_LEN_HI;
            end
          end
          jeop_pkg::PH_LEN_HI: begin
            seg_len_d = {b, 8'd0};
            phase_d   = jeop_pkg::PH_LEN_LO;
          end
          jeop_pkg::PH_LEN_LO: begin
            seg_len_d = len_now;
            seg_pos_d = '0;
            priority if (len_now < 16'd2) begin
              give = 1'b1;
            end else if (len_now == 16'd2) begin
              phase_d = jeop_pkg::PH_MARK;
            end else if (marker_q == jeop_pkg::CODE_APP1 && len_now >= 16'd8) begin
              phase_d = jeop_pkg::PH_SIG;
            end else begin
              phase_d = jeop_pkg::PH_SKIP;
            end
          end
          jeop_pkg::PH_SKIP, jeop_pkg::PH_HOLD: begin
            tail = 1'b1;
          end
          jeop_pkg::PH_SIG: begin
            tail = 1'b1;
            if (seg_pos_q < 16'd6 && b != jeop_pkg::exif_sig_byte(seg_pos_q[2:0])) begin
              phase_d = jeop_pkg::PH_SKIP;
            end else if (seg_pos_q >= 16'd5) begin
              phase_d = jeop_pkg::PH_TIFF;
              pend_d  = jeop_pkg::ORIENT_NORMAL;
            end
          end
          jeop_pkg::PH_TIFF: begin
            tail = 1'b1;
            if (seg_pos_q >= 16'd6 && tp < 16'd8) begin
              hdr_d[tp[2:0]] = b;
              if (tp == 16'd7) begin
                // Header complete: byte order, magic, IFD0 offset
                if (hdr_q[0] == jeop_pkg::BO_MOTOROLA && hdr_q[1] == jeop_pkg::BO_MOTOROLA) begin
                  be_new = 1'b1;
                  bo_ok  = 1'b1;
                end else if (hdr_q[0] == jeop_pkg::BO_INTEL &&
                             hdr_q[1] == jeop_pkg::BO_INTEL) begin
                  be_new = 1'b0;
                  bo_ok  = 1'b1;
                end
                off32 = be_new ? {hdr_q[4], hdr_q[5], hdr_q[6], b}
                               : {b, hdr_q[6], hdr_q[5], hdr_q[4]};
                off16 = off32[15:0];
                if (!bo_ok) begin
                  phase_d = jeop_pkg::PH_HOLD;
                end else begin
                  be_d = be_new;
                  if (jeop_pkg::get16(be_new, hdr_q[2], hdr_q[3]) != jeop_pkg::TIFF_MAGIC) begin
                    phase_d = jeop_pkg::PH_HOLD;
                  end else if (off32[31:16] != 16'd0 ||
                               ({5'd0, off16} + 21'd2) > tiff_sz) begin
                    phase_d = jeop_pkg::PH_HOLD;
                  end else begin
                    phase_d   = jeop_pkg::PH_IFD;
                    ifd_off_d = off16;
                    if (off16 < 16'd8) begin
                      enter_replay = 1'b1;
                      replay_d     = 1'b1;
                      rp_d         = off16[2:0];
                      tail         = 1'b0;
                    end
                  end
                end
              end
            end
          end
          jeop_pkg::PH_IFD: begin
            tail   = 1'b1;
            ifd_en = (seg_pos_q >= 16'd6);
          end
          jeop_pkg::PH_DONE: begin
            tail = 1'b0;
          end
          default: begin
            tail = 1'b0;
          end
        endcase
      end

      // IFD0 scan step
      if (ifd_en && tp >= ifd_off_q) begin
        if (tp == ifd_off_q) begin
          ent_b_d[0] = ib;
        end else if ({1'b0, tp} == {1'b0, ifd_off_q} + 17'd1) begin
          ent_b_d[1] = ib;
          cnt16      = jeop_pkg::get16(be_q, ent_b_q[0], ib);
          ent_cnt_d  = cnt16;
          ent_idx_d  = '0;
          ent_pos_d  = '0;
          need = {5'd0, ifd_off_q} + 21'd2 + ({5'd0, cnt16} << 3) + ({5'd0, cnt16} << 2);
          if (need > tiff_sz || cnt16 == 16'd0) phase_d = jeop_pkg::PH_HOLD;
        end else begin
          if (ent_pos_q < 4'd4) ent_b_d[ent_pos_q[1:0]] = ib;
          if (ent_pos_q == 4'd8) ent8_d = ib;
          ent_pos_d = (ent_pos_q >= jeop_pkg::ENTRY_LAST) ? 4'd0 : ent_pos_q + 4'd1;
          if (ent_pos_q == 4'd9) begin
            tag16   = jeop_pkg::get16(be_q, ent_b_q[0], ent_b_q[1]);
            typ16   = jeop_pkg::get16(be_q, ent_b_q[2], ent_b_q[3]);
            val16   = jeop_pkg::get16(be_q, ent8_q, ib);
            idx_inc = {1'b0, ent_idx_q} + 17'd1;
            if (tag16 == jeop_pkg::TAG_ORIENT && typ16 == jeop_pkg::TYPE_SHORT) begin
              pend_d  = (val16 >= 16'd1 && val16 <= {12'd0, jeop_pkg::ORIENT_MAX}) ?
                        val16[3:0] : jeop_pkg::ORIENT_NORMAL;
              phase_d = jeop_pkg::PH_HOLD;
            end else begin
              ent_idx_d = idx_inc[15:0];
              if (idx_inc >= {1'b0, ent_cnt_q}) phase_d = jeop_pkg::PH_HOLD;
            end
          end
        end
      end

      // Segment byte count and segment end
      if (tail) begin
        seg_pos_d = pos_inc;
        if (pos_inc >= seg_len_q - 16'd2) begin
          if (phase_d == jeop_pkg::PH_SKIP) begin
            phase_d = jeop_pkg::PH_MARK;
          end else begin
            answer = pend_d;
            give   = 1'b1;
          end
        end
      end

      // Result and end of file
      if (!enter_replay && !(replay_q && rp_q != 3'd7)) begin
        pop_o = 1'b1;
        if (give && !given_q) begin
          res_wr_o   = 1'b1;
          res_data_o = answer;
          given_d    = 1'b1;
          phase_d    = jeop_pkg::PH_DONE;
        end
        if (item_i.eof) begin
          if (!given_d) begin
            res_wr_o   = 1'b1;
            res_data_o = jeop_pkg::ORIENT_NORMAL;
          end
          phase_d  = jeop_pkg::PH_SOI0;
          given_d  = 1'b0;
          replay_d = 1'b0;
          pend_d   = jeop_pkg::ORIENT_NORMAL;
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= jeop_pkg::PH_SOI0;
      given_q  <= 1'b0;
      replay_q <= 1'b0;
      pend_q   <= jeop_pkg::ORIENT_NORMAL;
    end else begin
      phase_q  <= phase_d;
      given_q  <= given_d;
      replay_q <= replay_d;
      pend_q   <= pend_d;
    end
  end

  // Payload state
  always_ff @(posedge clk_i) begin
    seg_pos_q <= seg_pos_d;
    seg_len_q <= seg_len_d;
    marker_q  <= marker_d;
    be_q      <= be_d;
    hdr_q     <= hdr_d;
    ifd_off_q <= ifd_off_d;
    ent_cnt_q <= ent_cnt_d;
    ent_idx_q <= ent_idx_d;
    ent_b_q   <= ent_b_d;
    ent8_q    <= ent8_d;
    ent_pos_q <= ent_pos_d;
    rp_q      <= rp_d;
  end

  // Checks
  `JEOP_ASSERT_NEVER(a_wr_when_full, clk_i, rst_ni, res_wr_o && res_full_i)
  `JEOP_ASSERT(a_code_range, clk_i, rst_ni,
    res_wr_o |-> (res_data_o >= 4'd1 && res_data_o <= jeop_pkg::ORIENT_MAX))
  `JEOP_ASSERT(a_replay_phase, clk_i, rst_ni,
    replay_q |-> (phase_q == jeop_pkg::PH_IFD || phase_q == jeop_pkg::PH_HOLD))
  `JEOP_ASSERT(a_eof_restart, clk_i, rst_ni,
    (pop_o && item_i.eof) |=> (phase_q == jeop_pkg::PH_SOI0 && !given_q && !replay_q))

endmodule
`default_nettype wire

FILE: design/jpeg_exif_orientation_parser.sv
// Top level of the JPEG EXIF orientation parser.
// Takes one JPEG file byte per transaction (with a last-byte flag) and returns one
// orientation code 1..8 per file. Both sides are queues: an input byte is taken on
// push while full is low, a result is taken on pop while empty is low. The parser
// consumes one byte per clock; once per file, when the IFD0 offset points inside the
// 8-byte TIFF header, the header byte that completes it holds the parser while the IFD
// bytes are replayed from the kept header copy. The parser also waits while the 2-entry
// result queue is full. A result is written into the result queue at the same edge its
// byte leaves the 4-entry input queue, so on its way from the input ports to the result
// ports a byte passes the input queue and its result the result queue.
`default_nettype none
module jpeg_exif_orientation_parser (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] stream_byte_i,
  input  wire logic       end_of_file_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [3:0]      orientation_o
);

  jeop_pkg::item_t item;
  logic            item_valid, item_pop;
  logic            res_full, res_wr;
  logic [3:0]      res_data;

  // Front: classify and queue bytes
  jeop_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .stream_byte_i (stream_byte_i),
    .end_of_file_i (end_of_file_i),
    .item_o        (item),
    .item_valid_o  (item_valid),
    .item_pop_i    (item_pop)
  );

  // Back: parse segments and scan IFD0
  jeop_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item),
    .valid_i    (item_valid),
    .pop_o      (item_pop),
    .res_full_i (res_full),
    .res_wr_o   (res_wr),
    .res_data_o (res_data)
  );

  // Results waiting for the consumer
  jeop_rq u_rq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_wr),
    .data_i  (res_data),
    .full_o  (res_full),
    .empty_o (empty),
    .pop_i   (pop),
    .data_o  (orientation_o)
  );

endmodule
`default_nettype wire

FILE: dv/tb_jpeg_exif_orientation_parser.sv
// Testbench for the JPEG EXIF orientation parser: file stimulus, predictor and result checks.
`default_nettype none
module tb_jpeg_exif_orientation_parser;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  logic [7:0] stream_byte_i;
  logic       end_of_file_i;
  logic       empty;
  logic       pop;
  logic [3:0] orientation_o;

  jpeg_exif_orientation_parser i_dut (
    .clk_i, .rst_ni, .push, .full, .stream_byte_i, .end_of_file_i,
    .empty, .pop, .orientation_o
  );

  // Expected orientation codes, oldest first
  logic [3:0] orient_q[$];
  int unsigned n_mismatch;
  int unsigned n_checked;
  int unsigned n_bytes;
  int unsigned n_files;
  int unsigned pop_hold;      // requested receiver hold-off in cycles
  bit          pop_random;    // receiver stalls at random when set

  // Predictor state
  jeop_pkg::phase_e ph;
  logic [15:0] seg_pos, seg_len, ent_cnt, ent_idx;
  logic [7:0]  mk, ent_pos;
  logic        big_end, answered;
  logic [7:0]  hdr[8];
  logic [7:0]  ent[10];
  logic [31:0] ifd_off;
  logic [3:0]  pend;

  // Byte buffer of the file under construction
  logic [7:0] file_q[$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("timeout with %0d results still expected", orient_q.size());
    $display("tb_jpeg_exif_orientation_parser: done, errors");
    $finish;
  end

  function automatic logic [15:0] word16(input logic [7:0] b0, input logic [7:0] b1);
    return big_end ? {b0, b1} : {b1, b0};
  endfunction

  function automatic logic [7:0] sig_byte(input int unsigned idx);
    case (idx)
      0: return 8'h45;
      1: return 8'h78;
      2: return 8'h69;
      3: return 8'h66;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [31:0] tiff_bytes();
    return (seg_len >= 16'd8) ? 32'(seg_len) - 32'd8 : 32'd0;
  endfunction

  task automatic clear_parser();
    ph = jeop_pkg::PH_SOI0;
    seg_pos = '0; seg_len = '0; mk = '0; big_end = 1'b0;
    ifd_off = '0; ent_cnt = '0; ent_idx = '0; ent_pos = '0;
    pend = jeop_pkg::ORIENT_NORMAL; answered = 1'b0;
    foreach (hdr[i]) hdr[i] = '0;
    foreach (ent[i]) ent[i] = '0;
  endtask

  // One TIFF byte at offset tp while scanning IFD0
  task automatic ifd_step(input logic [31:0] tp, input logic [7:0] b);
    logic [31:0] rel;
    logic [7:0]  k;
    logic [15:0] v;
    if (ph != jeop_pkg::PH_IFD || tp < ifd_off) return;
    rel = tp - ifd_off;
    if (rel == 0) begin
      ent[0] = b;
      return;
    end
    if (rel == 1) begin
      ent[1] = b;
      ent_cnt = word16(ent[0], ent[1]);
      ent_idx = '0;
      ent_pos = '0;
      if (64'(ifd_off) + 64'd2 + 64'(ent_cnt) * 64'd12 > 64'(tiff_bytes()) || ent_cnt == 0)
        ph = jeop_pkg::PH_HOLD;
      return;
    end
    k = ent_pos;
    if (k < 10) ent[k] = b;
    if (k == 9) begin
      if (word16(ent[0], ent[1]) == jeop_pkg::TAG_ORIENT &&
          word16(ent[2], ent[3]) == jeop_pkg::TYPE_SHORT) begin
        v = word16(ent[8], ent[9]);
        pend = (v >= 1 && v <= 8) ? v[3:0] : jeop_pkg::ORIENT_NORMAL;
        ph = jeop_pkg::PH_HOLD;
        return;
      end
      ent_idx = ent_idx + 16'd1;
      if (ent_idx >= ent_cnt) begin
        ph = jeop_pkg::PH_HOLD;
        return;
      end
    end
    ent_pos = (k >= 8'(jeop_pkg::ENTRY_LAST)) ? 8'd0 : k + 8'd1;
  endtask

  // TIFF header complete: byte order, magic, IFD0 offset
  task automatic header_check();
    if (hdr[0] == jeop_pkg::BO_MOTOROLA && hdr[1] == jeop_pkg::BO_MOTOROLA) big_end = 1'b1;
    else if (hdr[0] == jeop_pkg::BO_INTEL && hdr[1] == jeop_pkg::BO_INTEL) big_end = 1'b0;
    else begin
      ph = jeop_pkg::PH_HOLD;
      return;
    end
    if (word16(hdr[2], hdr[3]) != jeop_pkg::TIFF_MAGIC) begin
      ph = jeop_pkg::PH_HOLD;
      return;
    end
    ifd_off = big_end ? {hdr[4], hdr[5], hdr[6], hdr[7]} : {hdr[7], hdr[6], hdr[5], hdr[4]};
    if (64'(ifd_off) + 64'd2 > 64'(tiff_bytes())) begin
      ph = jeop_pkg::PH_HOLD;
      return;
    end
    ph = jeop_pkg::PH_IFD;
    for (logic [31:0] t = ifd_off; t < 8; t++) ifd_step(t, hdr[t[2:0]]);
  endtask

  // Advance the predictor by one accepted byte, queue any expected code
  task automatic predict_orientation(input logic [7:0] b, input logic eof);
    logic        give;
    logic [3:0]  ans;
    logic [31:0] pos, tp;
    give = 1'b0;
    ans  = jeop_pkg::ORIENT_NORMAL;
    case (ph)
      jeop_pkg::PH_SOI0:
        if (b == jeop_pkg::MARK_PREFIX) ph = jeop_pkg::PH_SOI1; else give = 1'b1;
      jeop_pkg::PH_SOI1:
        if (b == jeop_pkg::CODE_SOI) ph = jeop_pkg::PH_MARK; else give = 1'b1;
      jeop_pkg::PH_MARK:
        if (b == jeop_pkg::MARK_PREFIX) ph = jeop_pkg::PH_CODE; else give = 1'b1;
      jeop_pkg::PH_CODE: begin
        if (b == jeop_pkg::MARK_PREFIX) ;
        else if (b == jeop_pkg::CODE_SOS) give = 1'b1;
        else if (b == jeop_pkg::CODE_SOI || b == jeop_pkg::CODE_EOI ||
                 (b >= jeop_pkg::CODE_RST0 && b <= jeop_pkg::CODE_RST7))
          ph = jeop_pkg::PH_MARK;
        else begin
          mk = b;
          ph = jeop_pkg::PH_LEN_HI;
        end
      end
      jeop_pkg::PH_LEN_HI: begin
        seg_len = {b, 8'h00};
        ph = jeop_pkg::PH_LEN_LO;
      end
      jeop_pkg::PH_LEN_LO: begin
        seg_len = seg_len | 16'(b);
        seg_pos = '0;
        if (seg_len < 2) give = 1'b1;
        else if (seg_len == 2) ph = jeop_pkg::PH_MARK;
        else if (mk == jeop_pkg::CODE_APP1 && seg_len >= 8) ph = jeop_pkg::PH_SIG;
        else ph = jeop_pkg::PH_SKIP;
      end
      jeop_pkg::PH_SKIP, jeop_pkg::PH_SIG, jeop_pkg::PH_TIFF, jeop_pkg::PH_IFD,
      jeop_pkg::PH_HOLD: begin
        pos = 32'(seg_pos);
        if (ph == jeop_pkg::PH_SIG) begin
          if (pos < 6 && b != sig_byte(pos)) ph = jeop_pkg::PH_SKIP;
          else if (pos >= 5) begin
            ph = jeop_pkg::PH_TIFF;
            pend = jeop_pkg::ORIENT_NORMAL;
          end
        end else if (ph == jeop_pkg::PH_TIFF) begin
          tp = pos - 32'd6;
          if (pos >= 6 && tp < 8) begin
            hdr[tp[2:0]] = b;
            if (tp == 7) header_check();
          end
        end else if (ph == jeop_pkg::PH_IFD) begin
          if (pos >= 6) ifd_step(pos - 32'd6, b);
        end
        seg_pos = seg_pos + 16'd1;
        if (32'(seg_pos) >= 32'(seg_len) - 32'd2) begin
          if (ph == jeop_pkg::PH_SKIP) ph = jeop_pkg::PH_MARK;
          else begin
            ans  = pend;
            give = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (give && !answered) begin
      orient_q.push_back(ans);
      answered = 1'b1;
      ph = jeop_pkg::PH_DONE;
    end
    if (eof) begin
      if (!answered) orient_q.push_back(jeop_pkg::ORIENT_NORMAL);
      clear_parser();
    end
  endtask

  // Send one byte; push stays high afterwards until a gap lowers it
  task automatic send_byte(input logic [7:0] b, input logic eof);
    @(negedge clk_i);
    push          <= 1'b1;
    stream_byte_i <= b;
    end_of_file_i <= eof;
    forever begin
      @(posedge clk_i);
      if (!full) break;
    end
    predict_orientation(b, eof);
    n_bytes++;
  endtask

  // Idle the sender for a random gap, mostly short, sometimes long
  task automatic sender_gap();
    int unsigned n;
    n = ($urandom_range(0, 9) < 6) ? 0 :
        ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    repeat (n) begin
      @(negedge clk_i);
      push <= 1'b0;
    end
  endtask

  // Send the buffered file, last byte flagged
  task automatic send_file(input bit gaps);
    for (int i = 0; i < file_q.size(); i++) begin
      send_byte(file_q[i], i == file_q.size() - 1);
      if (gaps) sender_gap();
    end
    file_q.delete();
    n_files++;
  endtask

  task automatic put16(input bit be, input logic [15:0] v);
    if (be) begin
      file_q.push_back(v[15:8]); file_q.push_back(v[7:0]);
    end else begin
      file_q.push_back(v[7:0]); file_q.push_back(v[15:8]);
    end
  endtask

  // Append an Exif APP1 segment; len_adj skews the length field
  task automatic add_exif(input bit be, input logic [15:0] magic, input logic [31:0] off,
                          input int unsigned n_ent, input logic [15:0] orient,
                          input int unsigned tag_at, input int len_adj);
    logic [7:0] body[$];
    int unsigned len;
    int seg;
    body = {8'h45, 8'h78, 8'h69, 8'h66, 8'h00, 8'h00};
    body.push_back(be ? jeop_pkg::BO_MOTOROLA : jeop_pkg::BO_INTEL);
    body.push_back(be ? jeop_pkg::BO_MOTOROLA : jeop_pkg::BO_INTEL);
    file_q = {file_q, 8'hFF, jeop_pkg::CODE_APP1, 8'h00, 8'h00};
    len = file_q.size();
    put16(be, magic);
    if (be) begin
      put16(1, off[31:16]); put16(1, off[15:0]);
    end else begin
      put16(0, off[15:0]); put16(0, off[31:16]);
    end
    for (int i = 8; i < off && i < 40; i++) file_q.push_back(8'($urandom));
    if (off >= 8) put16(be, 16'(n_ent));
    for (int e = 0; e < n_ent; e++) begin
      put16(be, (e == tag_at) ? jeop_pkg::TAG_ORIENT : 16'($urandom));
      put16(be, (e == tag_at || $urandom_range(0, 3) == 0) ? jeop_pkg::TYPE_SHORT :
                16'($urandom));
      put16(be, 16'd0); put16(be, 16'd1);
      put16(be, (e == tag_at) ? orient : 16'($urandom)); put16(be, 16'($urandom));
    end
    // signature and byte order go right after the length field
    for (int i = 0; i < 8; i++) file_q.insert(len + i, body[i]);
    seg = int'(file_q.size()) - int'(len) + 2 + len_adj;
    file_q[len - 2] = 8'(seg >> 8);
    file_q[len - 1] = 8'(seg);
    for (int i = 0; i < len_adj; i++) file_q.push_back(8'($urandom));
  endtask

  task automatic test_marker_cases();
    file_q = {8'h12}; send_file(1);                                  // bad first SOI byte
    file_q = {8'hFF, 8'hC0, 8'h00}; send_file(1);                    // bad second SOI byte
    file_q = {8'hFF, jeop_pkg::CODE_SOI, 8'h00, 8'h01}; send_file(1); // no prefix before marker
    file_q = {8'hFF, jeop_pkg::CODE_SOI, 8'hFF, 8'hFF, 8'hFF, jeop_pkg::CODE_SOS, 8'h55};
    send_file(1);
    file_q = {8'hFF, jeop_pkg::CODE_SOI, 8'hFF, 8'h00, 8'h00, 8'h01}; send_file(1); // len < 2
    file_q = {8'hFF, jeop_pkg::CODE_SOI, 8'hFF, 8'h01, 8'h00, 8'h02, 8'hFF, jeop_pkg::CODE_RST0,
              8'hFF, jeop_pkg::CODE_RST7, 8'hFF, jeop_pkg::CODE_EOI, 8'hFF, 8'hE0, 8'h00, 8'h04,
              8'hAA, 8'h55, 8'hFF, 8'hFE, 8'hFF, 8'hFF, 8'h00, 8'h00};
    send_file(0);                                                    // ends before an answer
  endtask

  task automatic test_exif_cases();
    file_q = {8'hFF, jeop_pkg::CODE_SOI}; add_exif(1, jeop_pkg::TIFF_MAGIC, 8, 2, 16'd8, 1, 0);
    file_q = {file_q, 8'hFF, jeop_pkg::CODE_SOS, 8'h00, 8'hFF}; send_file(1); // after answer
    file_q = {8'hFF, jeop_pkg::CODE_SOI}; add_exif(0, jeop_pkg::TIFF_MAGIC, 8, 1, 16'd0, 0, 0);
    send_file(1);
    file_q = {8'hFF, jeop_pkg::CODE_SOI}; add_exif(0, jeop_pkg::TIFF_MAGIC, 8, 1, 16'd9, 0, 2);
    send_file(1);
    file_q = {8'hFF, jeop_pkg::CODE_SOI}; add_exif(1, 16'h002B, 8, 1, 16'd3, 0, 0);
    send_file(1);
    file_q = {8'hFF, jeop_pkg::CODE_SOI}; add_exif(0, jeop_pkg::TIFF_MAGIC, 200, 0, 16'd3, 0, 0);
    send_file(1);
    file_q = {8'hFF, jeop_pkg::CODE_SOI}; add_exif(0, jeop_pkg::TIFF_MAGIC, 8, 3, 16'd3, 9, 0);
    send_file(1);
    file_q = {8'hFF, jeop_pkg::CODE_SOI}; add_exif(1, jeop_pkg::TIFF_MAGIC, 8, 3, 16'd3, 0, -30);
    send_file(1);
    file_q = {8'hFF, jeop_pkg::CODE_SOI}; add_exif(0, jeop_pkg::TIFF_MAGIC, 4, 4, 16'd6, 0, 8);
    send_file(1);
    file_q = {8'hFF, jeop_pkg::CODE_SOI}; add_exif(1, jeop_pkg::TIFF_MAGIC, 0, 2, 16'd2, 1, 0);
    send_file(1);
    // short TIFF data and a bad byte order
    file_q = {8'hFF, jeop_pkg::CODE_SOI, 8'hFF, jeop_pkg::CODE_APP1, 8'h00, 8'h0A, 8'h45,
              8'h78, 8'h69, 8'h66, 8'h00, 8'h00, 8'h4D, 8'h4D, 8'h00, 8'h2A};
    send_file(1);
    file_q = {8'hFF, jeop_pkg::CODE_SOI}; add_exif(1, jeop_pkg::TIFF_MAGIC, 8, 1, 16'd5, 0, 0);
    file_q[12] = jeop_pkg::BO_INTEL; send_file(1);
  endtask

  // Mostly well-formed files with random content, some noise and broken files
  task automatic test_random_files();
    int unsigned kind;
    while (n_bytes < 1750) begin
      kind = $urandom_range(0, 19);
      file_q = {8'hFF, jeop_pkg::CODE_SOI};
      if (kind < 2) begin
        file_q.delete();
        repeat ($urandom_range(1, 12)) file_q.push_back(8'($urandom));
      end else begin
        repeat ($urandom_range(0, 2)) begin
          case ($urandom_range(0, 3))
            0: file_q = {file_q, 8'hFF, 8'hFF, 8'hFF,
                         jeop_pkg::CODE_RST0 + 8'($urandom_range(0, 7))};
            1: file_q = {file_q, 8'hFF, jeop_pkg::CODE_EOI};
            default: begin
              file_q = {file_q, 8'hFF, 8'($urandom), 8'h00, 8'h05, 8'($urandom),
                        8'($urandom), 8'($urandom)};
            end
          endcase
        end
        add_exif($urandom_range(0, 1),
                 ($urandom_range(0, 9) == 0) ? 16'($urandom) : jeop_pkg::TIFF_MAGIC,
                 ($urandom_range(0, 4) == 0) ? 32'($urandom_range(0, 12)) :
                 ($urandom_range(0, 19) == 0) ? 32'($urandom) : 32'd8,
                 $urandom_range(0, 4),
                 ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 9)),
                 $urandom_range(0, 5),
                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) - 10 : 0);
        if (kind == 3) begin
          file_q[$urandom_range(0, file_q.size() - 1)] = 8'($urandom);
        end
        if (kind == 4) file_q = file_q[0:$urandom_range(0, file_q.size() - 1)];
        repeat ($urandom_range(0, 3)) file_q.push_back(8'($urandom));
      end
      send_file(1);
    end
  endtask

  // Receiver holds off while one-byte files keep coming, so the input stalls
  task automatic test_full_stall();
    @(negedge clk_i);
    push <= 1'b0;
    pop_hold = 80;
    repeat (30) begin
      file_q = {8'($urandom_range(0, 254))};
      send_file(0);
    end
  endtask

  // Result side: take results with random stalls and check them
  initial begin
    int unsigned stall;
    pop = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) begin
        n_checked++;
        if (orient_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("unexpected result: expected none, got %0d", orientation_o);
        end else begin
          if (orientation_o !== orient_q[0]) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("orientation mismatch: expected %0d, got %0d",
                       orient_q[0], orientation_o);
          end
          void'(orient_q.pop_front());
        end
      end
      @(negedge clk_i);
      if (pop_hold > 0) begin
        stall = pop_hold;
        pop_hold = 0;
      end else if (stall == 0 && pop_random && $urandom_range(0, 9) < 3) begin
        stall = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      end
      if (stall > 0) stall--;
      pop <= (stall == 0);
    end
  end

  initial begin
    rst_ni        = 1'b0;
    push          = 1'b0;
    stream_byte_i = '0;
    end_of_file_i = 1'b0;
    n_mismatch = 0; n_checked = 0; n_bytes = 0; n_files = 0;
    pop_hold = 0;
    pop_random = 1'b0;
    clear_parser();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_marker_cases();
    pop_random = 1'b1;
    test_exif_cases();
    test_full_stall();
    test_random_files();

    @(negedge clk_i);
    push <= 1'b0;
    while (orient_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    $display("sent %0d bytes in %0d files, checked %0d orientation codes",
             n_bytes, n_files, n_checked);
    $display("covered marker errors, Exif header faults, low IFD offsets and input stall");
    if (n_mismatch == 0) begin
      $display("tb_jpeg_exif_orientation_parser: done, clean");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("tb_jpeg_exif_orientation_parser: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
